// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL. Each use expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: rtl/core/fcfl_pkg.sv
`timescale 1ns / 1ps

package fcfl_pkg;

  localparam int unsigned CFG_W      = 9;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned MAX_CHUNKS = 256;
  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

  localparam logic [1:0] KIND_ALLOC    = 2'd0;
  localparam logic [1:0] KIND_FREE     = 2'd1;
  localparam logic [1:0] KIND_FREE_ALL = 2'd2;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_EMPTY  = 2'd1;
  localparam logic [1:0] STAT_BOUNDS = 2'd2;
  localparam logic [1:0] STAT_NULL   = 2'd3;

  typedef struct packed {
    logic accept;
    logic pop;
    logic fill_step;
    logic load_out;
  } fcfl_cmd_t;

  typedef struct packed {
    logic alloc_hit;
    logic fill_go;
    logic fill_last;
  } fcfl_stat_t;

endpackage

// File: rtl/core/fcfl_datapath.sv
`timescale 1ns / 1ps

module fcfl_datapath import fcfl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CFG_W-1:0]  cfg_wr_data,
  input  logic [1:0]        in_kind,
  input  logic [IDX_W-1:0]  in_chunk_index,
  input  logic              in_null_pointer,
  input  fcfl_cmd_t         cmd,
  output fcfl_stat_t        stat,
  output logic [IDX_W-1:0]  out_granted_index,
  output logic [1:0]        out_status
);

  localparam int unsigned AW = $clog2(MAX_CHUNKS);
  localparam int unsigned LW = $clog2(MAX_CHUNKS + 1);
  localparam int unsigned CW = (LW > CFG_W) ? LW : CFG_W;
  localparam logic [LW-1:0] EMPTY = LW'(MAX_CHUNKS);
  localparam logic [CW-1:0] CAP_C = CW'(MAX_CHUNKS);

  logic [CFG_W-1:0] chunk_count_r;
  logic [LW-1:0]    head_r, head_nxt;
  logic [AW-1:0]    fill_cnt_r, fill_cnt_nxt;
  logic [LW-1:0]    rd_data_r;
  logic [LW-1:0]    mem [0:MAX_CHUNKS-1];
  logic [IDX_W-1:0] res_granted_r;
  logic [1:0]       res_status_r;

  logic [LW-1:0]    eff_count;
  logic             head_empty;
  logic             in_bounds;
  logic             free_ok;
  logic [IDX_W-1:0] acc_granted;
  logic [1:0]       acc_status;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [LW-1:0]    mem_wdata;

  always_comb begin
    eff_count  = (CW'(chunk_count_r) > CAP_C) ? EMPTY : LW'(chunk_count_r);
    head_empty = (head_r >= EMPTY);
    in_bounds  = (CW'(in_chunk_index) < CW'(eff_count));
    free_ok    = (in_kind == KIND_FREE) && !in_null_pointer && in_bounds;

    acc_granted = '0;
    acc_status  = STAT_OK;
    unique case (in_kind)
      KIND_ALLOC: begin
        if (head_empty) begin
          acc_status = STAT_EMPTY;
        end else begin
          acc_granted = IDX_W'(head_r);
        end
      end
      KIND_FREE: begin
        if (in_null_pointer) begin
          acc_status = STAT_NULL;
        end else if (!in_bounds) begin
          acc_status = STAT_BOUNDS;
        end
      end
      default: begin
        acc_status = STAT_OK;
      end
    endcase

    stat.alloc_hit = (in_kind == KIND_ALLOC) && !head_empty;
    stat.fill_go   = (in_kind == KIND_FREE_ALL) && (eff_count != '0);
    stat.fill_last = (fill_cnt_r == AW'(eff_count - LW'(1)));

    mem_we = cmd.fill_step || (cmd.accept && free_ok);
    if (cmd.fill_step) begin
      mem_waddr = fill_cnt_r;
      mem_wdata = (fill_cnt_r == '0) ? EMPTY : (LW'(fill_cnt_r) - LW'(1));
    end else begin
      mem_waddr = AW'(in_chunk_index);
      mem_wdata = head_r;
    end

    priority if (cmd.accept && free_ok) begin
      head_nxt = LW'(in_chunk_index);
    end else if (cmd.accept && (in_kind == KIND_FREE_ALL)) begin
      head_nxt = EMPTY;
    end else if (cmd.pop) begin
      head_nxt = rd_data_r;
    end else if (cmd.fill_step && stat.fill_last) begin
      head_nxt = LW'(fill_cnt_r);
    end else begin
      head_nxt = head_r;
    end

    priority if (cmd.accept) begin
      fill_cnt_nxt = '0;
    end else if (cmd.fill_step) begin
      fill_cnt_nxt = fill_cnt_r + AW'(1);
    end else begin
      fill_cnt_nxt = fill_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_count_r <= CFG_RESET;
      head_r        <= EMPTY;
      fill_cnt_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        chunk_count_r <= cfg_wr_data;
      end
      head_r     <= head_nxt;
      fill_cnt_r <= fill_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[head_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_granted_r <= acc_granted;
      res_status_r  <= acc_status;
    end
    if (cmd.load_out) begin
      out_granted_index <= cmd.accept ? acc_granted : res_granted_r;
      out_status        <= cmd.accept ? acc_status : res_status_r;
    end
  end

endmodule

// File: rtl/core/fcfl_ctrl.sv
`timescale 1ns / 1ps

module fcfl_ctrl import fcfl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  fcfl_stat_t stat,
  output fcfl_cmd_t  cmd
);

  typedef enum logic [1:0] {S_IDLE, S_POP, S_FILL, S_DONE} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;
  logic   out_free;
  logic   finish;

  always_comb begin
    out_free  = !out_valid_r || out_ready;
    finish    = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (stat.alloc_hit) begin
            state_nxt = S_POP;
          end else if (stat.fill_go) begin
            state_nxt = S_FILL;
          end else begin
            finish = 1'b1;
          end
        end
      end
      S_POP: begin
        finish = 1'b1;
      end
      S_FILL: begin
        finish = stat.fill_last;
      end
      S_DONE: begin
        finish = 1'b1;
      end
    endcase
    if (finish) begin
      state_nxt = out_free ? S_IDLE : S_DONE;
    end

    cmd.accept    = (state_r == S_IDLE) && in_valid;
    cmd.pop       = (state_r == S_POP);
    cmd.fill_step = (state_r == S_FILL);
    cmd.load_out  = finish && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: rtl/core/fixed_chunk_free_list_allocator_top.sv
`timescale 1ns / 1ps
// Pool allocator for equal chunks named by index, kept as a LIFO free list.
// Requests arrive on the in_ channel (valid/ready); each one produces exactly
// one transfer on the out_ channel with the granted index and a status code.
// Allocate pops the list head, free pushes one chunk, free-all rebuilds the
// list with the highest chunk on top. The user must write the chunk count on
// the cfg_ port only while the block is idle (the block does not enforce it);
// the count takes effect on the next request. Free and unused requests and an
// allocate on an empty pool finish in the cycle they are accepted; a granting
// allocate waits in the POP state for the registered read of the link memory.
// Free-all writes one link per cycle in the FILL state. Requests do not
// overlap, so a new request is accepted in the cycle after the last finishes.
// A finished result sits in the output register; a new request is accepted
// while it waits. If the receiver stalls and the next result is also done,
// the block holds it and stops accepting until the output register drains.
// After reset the free list is empty and the chunk count is 256; the link
// memory is not cleared, since each entry is written before it is read.

`include "assert_macros.svh"

module fixed_chunk_free_list_allocator_top import fcfl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CFG_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_kind,
  input  logic [IDX_W-1:0]  in_chunk_index,
  input  logic              in_null_pointer,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [IDX_W-1:0]  out_granted_index,
  output logic [1:0]        out_status
);

  fcfl_cmd_t  cmd;
  fcfl_stat_t stat;

  fcfl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fcfl_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_kind           (in_kind),
    .in_chunk_index    (in_chunk_index),
    .in_null_pointer   (in_null_pointer),
    .cmd               (cmd),
    .stat              (stat),
    .out_granted_index (out_granted_index),
    .out_status        (out_status)
  );

  `ASSERT_NEXT(a_alloc_pops, cmd.accept && stat.alloc_hit, cmd.pop && !in_ready)
  `ASSERT_SAME(a_no_overwrite, cmd.load_out, !out_valid || out_ready)
  `ASSERT_SAME(a_fill_blocks_input, cmd.fill_step, !in_ready && !cmd.accept)
  `ASSERT_NEXT(a_load_shows, cmd.load_out, out_valid)

endmodule

// File: test/fixed_chunk_free_list_allocator_top_tb.sv
`timescale 1ns / 1ps

module fixed_chunk_free_list_allocator_top_tb;
  import fcfl_pkg::*;

  localparam int POOL_SIZE = 256;
  localparam logic [8:0] EMPTY_LINK = 9'd256;
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int SCORE = 0;
  localparam int PLAN = 1;
  localparam int PHASE_ITEMS = 75;

  typedef struct packed {
    logic [1:0] kind;
    logic [IDX_W-1:0] chunk;
    logic null_ptr;
  } request_t;

  typedef struct packed {
    logic [IDX_W-1:0] granted;
    logic [1:0] status;
  } grant_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_kind = KIND_ALLOC;
  logic [IDX_W-1:0] in_chunk_index = '0;
  logic in_null_pointer = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [IDX_W-1:0] out_granted_index;
  logic [1:0] out_status;

  // Two copies of the pool: one follows accepted transfers, one plans stimulus.
  logic [8:0] pool_head [2];
  logic [8:0] pool_link [2][POOL_SIZE];
  logic [CFG_W-1:0] pool_count [2];

  request_t pending_requests [$];
  grant_t awaited_grants [$];
  logic [IDX_W-1:0] held_chunks [$];
  int requests_planned = 0;
  int grants_checked = 0;
  int failures = 0;
  int send_gap = 0;
  int stall_left = 0;
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;

  fixed_chunk_free_list_allocator_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_kind(in_kind),
    .in_chunk_index(in_chunk_index),
    .in_null_pointer(in_null_pointer),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_granted_index(out_granted_index),
    .out_status(out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void run_pool_request(input int w, input request_t req,
                                           output grant_t res);
    int eff;
    eff = (pool_count[w] > POOL_SIZE) ? POOL_SIZE : int'(pool_count[w]);
    res.granted = '0;
    res.status = STAT_OK;
    case (req.kind)
      KIND_ALLOC: begin
        if (pool_head[w] >= EMPTY_LINK) begin
          res.status = STAT_EMPTY;
        end else begin
          res.granted = pool_head[w][IDX_W-1:0];
          pool_head[w] = pool_link[w][pool_head[w][IDX_W-1:0]];
        end
      end
      KIND_FREE: begin
        if (req.null_ptr) begin
          res.status = STAT_NULL;
        end else if (int'(req.chunk) >= eff) begin
          res.status = STAT_BOUNDS;
        end else begin
          pool_link[w][req.chunk] = pool_head[w];
          pool_head[w] = {1'b0, req.chunk};
        end
      end
      KIND_FREE_ALL: begin
        pool_head[w] = EMPTY_LINK;
        for (int i = 0; i < eff; i++) begin
          pool_link[w][i] = pool_head[w];
          pool_head[w] = i[8:0];
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  always @(posedge clk) begin : drive_requests
    request_t nxt;
    grant_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if ($urandom_range(299) == 0) begin
        send_calm <= !send_calm;
      end
      if (in_valid && in_ready) begin
        run_pool_request(SCORE, '{in_kind, in_chunk_index, in_null_pointer}, res);
        awaited_grants.push_back(res);
      end
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_requests.size() != 0) begin
          nxt = pending_requests.pop_front();
          in_kind <= nxt.kind;
          in_chunk_index <= nxt.chunk;
          in_null_pointer <= nxt.null_ptr;
          in_valid <= 1'b1;
          send_gap <= send_calm ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_grants
    grant_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if ($urandom_range(299) == 0) begin
        recv_calm <= !recv_calm;
      end
      if (out_valid && out_ready) begin
        if (awaited_grants.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, actual granted %0d status %0d",
                   $time, out_granted_index, out_status);
          failures++;
        end else begin
          want = awaited_grants.pop_front();
          grants_checked++;
          if (out_granted_index !== want.granted) begin
            $display("%0t: granted_index mismatch, expected %0d, actual %0d",
                     $time, want.granted, out_granted_index);
            failures++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, out_status);
            failures++;
          end
        end
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_ready <= 1'b1;
        stall_left <= (recv_calm || $urandom_range(2) != 0) ? 0 : pick_gap();
      end
    end
  end

  task automatic queue_request(input logic [1:0] kind, input logic [IDX_W-1:0] chunk,
                               input logic null_ptr);
    request_t req;
    grant_t res;
    req = '{kind, chunk, null_ptr};
    run_pool_request(PLAN, req, res);
    if (kind == KIND_ALLOC && res.status == STAT_OK) begin
      held_chunks.push_back(res.granted);
    end else if (kind == KIND_FREE && res.status == STAT_OK) begin
      for (int i = 0; i < held_chunks.size(); i++) begin
        if (held_chunks[i] == chunk) begin
          held_chunks.delete(i);
          break;
        end
      end
    end else if (kind == KIND_FREE_ALL) begin
      held_chunks.delete();
    end
    pending_requests.push_back(req);
    requests_planned++;
  endtask

  task automatic wait_pool_idle();
    while (pending_requests.size() != 0 || grants_checked != requests_planned) begin
      @(negedge clk);
    end
  endtask

  task automatic set_chunk_count(input logic [CFG_W-1:0] value);
    wait_pool_idle();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    pool_count[SCORE] = value;
    pool_count[PLAN] = value;
  endtask

  task automatic queue_random_request();
    int eff;
    int r;
    int pos;
    logic [IDX_W-1:0] any;
    eff = (pool_count[PLAN] > POOL_SIZE) ? POOL_SIZE : int'(pool_count[PLAN]);
    any = IDX_W'($urandom_range(255));
    r = $urandom_range(99);
    if (r < 42) begin
      queue_request(KIND_ALLOC, any, 1'($urandom_range(1)));
    end else if (r < 78 && held_chunks.size() != 0) begin
      pos = $urandom_range(held_chunks.size() - 1);
      queue_request(KIND_FREE, held_chunks[pos], 1'b0);
    end else if (r < 82 && eff > 0) begin
      queue_request(KIND_FREE, IDX_W'($urandom_range(eff - 1)), 1'b0);
    end else if (r < 87 && eff < POOL_SIZE) begin
      queue_request(KIND_FREE, IDX_W'($urandom_range(POOL_SIZE - 1, eff)), 1'b0);
    end else if (r < 91) begin
      queue_request(KIND_FREE, any, 1'b1);
    end else if (r < 94) begin
      queue_request(KIND_SPARE, any, 1'($urandom_range(1)));
    end else if (r < 97) begin
      queue_request(KIND_FREE_ALL, any, 1'($urandom_range(1)));
    end else begin
      queue_request(KIND_ALLOC, any, 1'b0);
    end
  endtask

  initial begin
    #10_000_000;
    $display("fixed_chunk_free_list_allocator_top_tb failed");
    $finish;
  end

  initial begin
    logic [CFG_W-1:0] phase_counts [10];
    phase_counts = '{9'd256, 9'd2, 9'd511, 9'd0, 9'd37, 9'd1, 9'd300, 9'd128, 9'd5, 9'd255};
    for (int w = 0; w < 2; w++) begin
      pool_head[w] = EMPTY_LINK;
      pool_count[w] = CFG_RESET;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    queue_request(KIND_ALLOC, 8'd0, 1'b0);
    queue_request(KIND_SPARE, 8'd255, 1'b1);
    queue_request(KIND_FREE, 8'd0, 1'b1);
    queue_request(KIND_FREE, 8'd255, 1'b0);
    queue_request(KIND_ALLOC, 8'd0, 1'b0);
    queue_request(KIND_ALLOC, 8'd0, 1'b0);
    queue_request(KIND_FREE_ALL, 8'd255, 1'b1);
    queue_request(KIND_ALLOC, 8'd255, 1'b1);
    queue_request(KIND_ALLOC, 8'd0, 1'b0);
    queue_request(KIND_FREE, 8'd255, 1'b0);
    queue_request(KIND_ALLOC, 8'd0, 1'b0);
    set_chunk_count(9'd0);
    queue_request(KIND_FREE_ALL, 8'd0, 1'b0);
    queue_request(KIND_ALLOC, 8'd0, 1'b0);
    queue_request(KIND_FREE, 8'd0, 1'b0);
    set_chunk_count(9'd1);
    queue_request(KIND_FREE_ALL, 8'd0, 1'b0);
    queue_request(KIND_ALLOC, 8'd0, 1'b0);
    queue_request(KIND_ALLOC, 8'd0, 1'b0);
    queue_request(KIND_FREE, 8'd1, 1'b0);
    queue_request(KIND_FREE, 8'd255, 1'b1);
    queue_request(KIND_FREE, 8'd0, 1'b0);
    set_chunk_count(9'd511);
    queue_request(KIND_FREE_ALL, 8'd0, 1'b0);
    queue_request(KIND_FREE, 8'd255, 1'b0);
    set_chunk_count(9'd3);
    queue_request(KIND_ALLOC, 8'd0, 1'b0);
    queue_request(KIND_FREE, 8'd254, 1'b0);
    queue_request(KIND_FREE, 8'd255, 1'b0);
    queue_request(KIND_ALLOC, 8'd0, 1'b0);

    for (int p = 0; p < 10; p++) begin
      set_chunk_count(phase_counts[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p % 2 == 0 && n == PHASE_ITEMS / 2) begin
          wait_pool_idle();
        end
        queue_random_request();
      end
    end

    wait_pool_idle();
    repeat (20) @(posedge clk);
    if (awaited_grants.size() != 0) begin
      $display("%0t: %0d transfers still expected, actual none", $time,
               awaited_grants.size());
      failures++;
    end
    if (failures == 0) begin
      $display("fixed_chunk_free_list_allocator_top_tb passed");
    end else begin
      $display("fixed_chunk_free_list_allocator_top_tb failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/fcfl_pkg.sv
rtl/core/fcfl_datapath.sv
rtl/core/fcfl_ctrl.sv
rtl/core/fixed_chunk_free_list_allocator_top.sv
test/fixed_chunk_free_list_allocator_top_tb.sv
